/* src/checked_int64_alu_assert.svh */
// Assertion macros for the checked 64-bit integer unit.
`ifndef CHECKED_INT64_ALU_ASSERT_SVH
`define CHECKED_INT64_ALU_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define CIA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* src/cia_pkg.sv */
// ----------------------------------------------------------------------------
// Checked 64-bit integer unit package
// Operation and status codes, stage payload type and shared constants.
// ----------------------------------------------------------------------------
package cia_pkg;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned NumCells = 64;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_REM = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_OVF = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef struct packed {
    logic valid;
    logic [2:0] kind;
    logic neg_q;
    logic neg_r;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] divisor;
    logic [63:0] value;
    logic [1:0] status;
    logic done;
  } stage_t;
endpackage

/* src/cia_prep.sv */
// ----------------------------------------------------------------------------
// Checked 64-bit integer unit front stage
// Computes add and subtract results and sets up the multiply and divide chain.
// ----------------------------------------------------------------------------
module cia_prep import cia_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [2:0]  kind,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output stage_t      stage
);
  stage_t s_next;
  logic [63:0] ma, mb, r;
  logic neg;

  always_comb begin
    ma = a[63] ? (64'd0 - a) : a;
    mb = b[63] ? (64'd0 - b) : b;
    neg = a[63] ^ b[63];
    r = 64'd0;
    s_next = '0;
    s_next.valid = in_valid;
    s_next.kind = kind;
    s_next.neg_q = neg;
    s_next.neg_r = a[63];
    s_next.quo = ma;
    s_next.divisor = mb;
    s_next.status = ST_OK;
    s_next.done = 1'b1;
    case (kind)
      KIND_ADD: begin
        r = a + b;
        if ((a[63] ^ r[63]) & (b[63] ^ r[63])) s_next.status = ST_OVF;
        else s_next.value = r;
      end
      KIND_SUB: begin
        r = a - b;
        if ((a[63] ^ b[63]) & (a[63] ^ r[63])) s_next.status = ST_OVF;
        else s_next.value = r;
      end
      KIND_MUL: begin
        s_next.done = 1'b0;
      end
      KIND_DIV, KIND_REM: begin
        if (b == 64'd0) s_next.status = ST_DIV0;
        else if (a == 64'h8000_0000_0000_0000 && b == '1) begin
          if (kind == KIND_DIV) s_next.status = ST_OVF;
        end else s_next.done = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) stage.valid <= 1'b0;
    else if (en) stage <= s_next;
  end
endmodule

/* src/cia_cell.sv */
// ----------------------------------------------------------------------------
// Checked 64-bit integer unit arithmetic cell
// One restoring division step or one shift-and-add multiply step; passes the
// item on to the next cell.
// ----------------------------------------------------------------------------
module cia_cell import cia_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  stage_t din,
  output stage_t dout
);
  stage_t s_next;
  logic [64:0] trial;
  logic [64:0] shifted;
  logic [64:0] sum;

  always_comb begin
    s_next = din;
    shifted = {din.rem, din.quo[63]};
    trial = shifted - {1'b0, din.divisor};
    sum = {1'b0, din.rem} + (din.quo[0] ? {1'b0, din.divisor} : 65'd0);
    if (!din.done) begin
      if (din.kind == KIND_MUL) begin
        s_next.rem = sum[64:1];
        s_next.quo = {sum[0], din.quo[63:1]};
      end else if (!trial[64]) begin
        s_next.rem = trial[63:0];
        s_next.quo = {din.quo[62:0], 1'b1};
      end else begin
        s_next.rem = shifted[63:0];
        s_next.quo = {din.quo[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (en) dout <= s_next;
  end
endmodule

/* src/checked_int64_alu.sv */
// ----------------------------------------------------------------------------
// Checked 64-bit integer unit
// Signed add, subtract, multiply, divide and remainder with status.
// ----------------------------------------------------------------------------
// Accepts one item every cycle while not stalled; each item passes through a row
// of 64 cells, each doing one step of a shift-and-add multiply or of a restoring
// divide, behind a front stage and ahead of an output stage that settles sign and
// overflow. The whole pipe stalls while the output waits to be taken.
module checked_int64_alu import cia_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // kind[2:0], operand_a[66:3], operand_b[130:67]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata   // result_value[63:0], status[65:64]
);
  `include "checked_int64_alu_assert.svh"

  logic en;
  stage_t chain [NumCells+1];
  logic [63:0] res;
  logic [1:0] st;
  logic [127:0] prod;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  cia_prep u_prep (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .kind(s_tdata[2:0]), .a(s_tdata[66:3]), .b(s_tdata[130:67]),
    .stage(chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cia_cell u_cell (.clk(clk), .rst(rst), .en(en), .din(chain[i]), .dout(chain[i+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) begin
      m_tvalid <= chain[NumCells].valid;
      m_tdata <= {6'd0, st, res};
    end
  end

  always_comb begin
    st = chain[NumCells].status;
    res = chain[NumCells].value;
    prod = {chain[NumCells].rem, chain[NumCells].quo};
    if (!chain[NumCells].done) begin
      case (chain[NumCells].kind)
        KIND_MUL: begin
          if (prod[127:64] != 64'd0) st = ST_OVF;
          else if (chain[NumCells].neg_q) begin
            if (prod[63:0] > 64'h8000_0000_0000_0000) st = ST_OVF;
            else res = 64'd0 - prod[63:0];
          end else if (prod[63]) st = ST_OVF;
          else res = prod[63:0];
        end
        KIND_DIV: begin
          res = chain[NumCells].neg_q ? (64'd0 - chain[NumCells].quo) : chain[NumCells].quo;
        end
        default: begin
          res = chain[NumCells].neg_r ? (64'd0 - chain[NumCells].rem) : chain[NumCells].rem;
        end
      endcase
    end
  end

  `CIA_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
  `CIA_ASSERT_IMP(a_zero_on_error, m_tvalid && m_tdata[65:64] != ST_OK,
                  m_tdata[63:0] == 64'd0)
  `CIA_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

/* tb/tb_checked_int64_alu.sv */
// ----------------------------------------------------------------------------
// Checked 64-bit integer unit testbench
// Drives directed and random operations through the stream ports, predicts
// each result and status, and compares results in order under random stalls.
// ----------------------------------------------------------------------------
class alu_scoreboard;
  logic [63:0] want_value[$];
  logic [1:0] want_status[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function void note_operation(logic [2:0] kind, logic [63:0] a, logic [63:0] b);
    logic [63:0] val;
    logic [1:0] st;
    logic [63:0] r;
    logic [127:0] prod;
    logic [63:0] ma;
    logic [63:0] mb;
    logic neg;
    val = '0;
    st = cia_pkg::ST_OK;
    ma = magnitude(a);
    mb = magnitude(b);
    neg = a[63] ^ b[63];
    case (kind)
      cia_pkg::KIND_ADD: begin
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63])) st = cia_pkg::ST_OVF;
        else val = r;
      end
      cia_pkg::KIND_SUB: begin
        r = a - b;
        if ((a[63] != b[63]) && (r[63] != a[63])) st = cia_pkg::ST_OVF;
        else val = r;
      end
      cia_pkg::KIND_MUL: begin
        prod = {64'd0, ma} * {64'd0, mb};
        if (prod[127:64] != 0) st = cia_pkg::ST_OVF;
        else if (neg) begin
          if (prod[63:0] > 64'h8000_0000_0000_0000) st = cia_pkg::ST_OVF;
          else val = 64'd0 - prod[63:0];
        end else begin
          if (prod[63]) st = cia_pkg::ST_OVF;
          else val = prod[63:0];
        end
      end
      cia_pkg::KIND_DIV, cia_pkg::KIND_REM: begin
        if (b == 0) st = cia_pkg::ST_DIV0;
        else if (a == 64'h8000_0000_0000_0000 && b == '1) begin
          if (kind == cia_pkg::KIND_DIV) st = cia_pkg::ST_OVF;
        end else if (kind == cia_pkg::KIND_DIV) begin
          r = ma / mb;
          val = neg ? (64'd0 - r) : r;
        end else begin
          r = ma % mb;
          val = a[63] ? (64'd0 - r) : r;
        end
      end
      default: ;
    endcase
    want_value.push_back(val);
    want_status.push_back(st);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] exp);
    errors++;
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
  endtask

  task check_result(logic [71:0] data);
    logic [63:0] v;
    logic [1:0] s;
    checked++;
    if (want_value.size() == 0) begin
      report("unexpected result", data[63:0], 0);
    end else begin
      v = want_value.pop_front();
      s = want_status.pop_front();
      if (data[63:0] !== v) report("result_value", data[63:0], v);
      if (data[65:64] !== s) report("status", {62'd0, data[65:64]}, {62'd0, s});
    end
  endtask
endclass

module tb_checked_int64_alu;
  import cia_pkg::*;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
  localparam int Latency = 65;
  localparam int IdleLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;

  alu_scoreboard board = new();
  logic hold_off = 1'b0;
  int idle_cycles = 0;
  int sent = 0;

  checked_int64_alu i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MinVal;
      1: return MaxVal;
      2: return '1;
      3: return 64'd0;
      4: return 64'd1;
      5: return {{32{$urandom_range(0, 1) == 1}}, $urandom()};
      6: return {{48{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return rand64();
    endcase
  endfunction

  task send_operation(logic [2:0] kind, logic [63:0] a, logic [63:0] b);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {5'd0, b, a, kind};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_operation(kind, a, b);
    sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : receiver
    int wait_n;
    bit stall_done;
    stall_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off && !stall_done) begin
        m_tready <= 1'b0;
        repeat (1000) @(negedge clk);
        stall_done = 1'b1;
      end
      wait_n = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [63:0] edge_vals[6];
    int w;
    edge_vals = '{MinVal, MaxVal, '1, 64'd0, 64'd1, 64'h0000_0001_0000_0000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_operation(KIND_ADD, MaxVal, 64'd1);
    send_operation(KIND_ADD, MinVal, '1);
    send_operation(KIND_ADD, MinVal, MaxVal);
    send_operation(KIND_SUB, MinVal, 64'd1);
    send_operation(KIND_SUB, MaxVal, '1);
    send_operation(KIND_SUB, 64'd0, MinVal);
    send_operation(KIND_MUL, MinVal, '1);
    send_operation(KIND_MUL, MinVal, 64'd1);
    send_operation(KIND_MUL, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
    send_operation(KIND_MUL, 64'h0000_0001_0000_0000, 64'hffff_ffff_8000_0000);
    send_operation(KIND_MUL, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000);
    send_operation(KIND_MUL, MaxVal, MaxVal);
    send_operation(KIND_DIV, MinVal, '1);
    send_operation(KIND_REM, MinVal, '1);
    send_operation(KIND_DIV, 64'd7, 64'd0);
    send_operation(KIND_REM, MinVal, 64'd0);
    send_operation(KIND_DIV, -64'sd7, 64'd2);
    send_operation(KIND_REM, -64'sd7, 64'd2);
    send_operation(KIND_REM, 64'd7, -64'sd2);
    send_operation(KIND_DIV, MaxVal, MinVal);
    send_operation(3'd5, MaxVal, MaxVal);
    send_operation(3'd6, '1, '1);
    send_operation(3'd7, MinVal, 64'd3);
    for (int i = 0; i < 950; i++) begin
      if (i == 400) hold_off = 1'b1;
      if ($urandom_range(0, 3) == 0)
        send_operation(3'($urandom_range(0, 4)), edge_vals[$urandom_range(0, 5)],
                       edge_vals[$urandom_range(0, 5)]);
      else if ($urandom_range(0, 19) == 0)
        send_operation(3'($urandom_range(5, 7)), rand64(), rand64());
      else
        send_operation(3'($urandom_range(0, 4)), pick_operand(), pick_operand());
    end
    s_tvalid <= 1'b0;
    w = 0;
    while (board.want_value.size() != 0 && w < 50000) begin
      @(posedge clk);
      w++;
    end
    repeat (Latency + 20) @(posedge clk);
    $display("Covered %0d operations of every kind, with overflow, divide by zero,", sent);
    $display("edge operands, random stalls on both sides and one long output stall.");
    if (board.errors == 0 && board.want_value.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
